[design/rsmm_pkg.sv]
// shared types and constants for the row-streamed matrix multiply core
package rsmm_pkg;

  // item kinds carried in the input tuser
  localparam logic KIND_LOAD_B = 1'b0;
  localparam logic KIND_ROW_A  = 1'b1;

  // stream widths
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 80;
  localparam int SIZE_W     = 7;

  // internal exponent arithmetic
  localparam int EXP_W = 13;
  localparam logic signed [EXP_W-1:0] ZERO_EXP      = -13'sd2048;
  localparam logic signed [EXP_W-1:0] F32_BIAS_ADJ  = 13'sd150;
  localparam logic signed [EXP_W-1:0] F32_SUB_EXP   = -13'sd149;
  localparam logic signed [EXP_W-1:0] F64_BIAS      = 13'sd1023;
  localparam logic signed [EXP_W-1:0] F64_EXP_TOP   = 13'sd2047;

  localparam logic [63:0] CANON_NAN = 64'h7FF8_0000_0000_0000;

  // pipeline depths of the arithmetic units
  localparam int MUL_LAT    = 3;
  localparam int ADD_LAT    = 6;
  localparam int PIPE_DEPTH = 1 + MUL_LAT + ADD_LAT;

  // exact product, normalized with its leading one at bit 52
  typedef struct packed {
    logic                    nan;
    logic                    inf;
    logic                    zero;
    logic                    sign;
    logic signed [EXP_W-1:0] exp;
    logic [52:0]             mant;
  } prod_t;

endpackage

[design/rsmm_mul_unit.sv]
// pipelined binary32 x binary32 multiplier with an exact normalized result
module rsmm_mul_unit
  import rsmm_pkg::*;
(
  input  logic        clk,
  input  logic [31:0] a_bits,
  input  logic [31:0] b_bits,
  output prod_t       prod
);

  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    n = 6'd47;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

  logic [7:0]              a_ex, b_ex;
  logic [22:0]             a_fr, b_fr;
  logic [23:0]             a_m, b_m;
  logic signed [EXP_W-1:0] a_e, b_e;
  logic                    a_zero, b_zero, a_inf, b_inf, a_nan, b_nan;

  // unpack both operands
  assign a_ex   = a_bits[30:23];
  assign b_ex   = b_bits[30:23];
  assign a_fr   = a_bits[22:0];
  assign b_fr   = b_bits[22:0];
  assign a_m    = {a_ex != 8'd0, a_fr};
  assign b_m    = {b_ex != 8'd0, b_fr};
  assign a_e    = (a_ex == 8'd0) ? F32_SUB_EXP : signed'({5'b0, a_ex}) - F32_BIAS_ADJ;
  assign b_e    = (b_ex == 8'd0) ? F32_SUB_EXP : signed'({5'b0, b_ex}) - F32_BIAS_ADJ;
  assign a_zero = (a_ex == 8'd0) && (a_fr == 23'd0);
  assign b_zero = (b_ex == 8'd0) && (b_fr == 23'd0);
  assign a_inf  = (a_ex == 8'hFF) && (a_fr == 23'd0);
  assign b_inf  = (b_ex == 8'hFF) && (b_fr == 23'd0);
  assign a_nan  = (a_ex == 8'hFF) && (a_fr != 23'd0);
  assign b_nan  = (b_ex == 8'hFF) && (b_fr != 23'd0);

  logic [47:0]             s1_m, s2_m;
  logic signed [EXP_W-1:0] s1_e, s2_e;
  logic                    s1_sign, s1_zero, s1_inf, s1_nan;
  logic                    s2_sign, s2_zero, s2_inf, s2_nan;
  logic [5:0]              s2_lz;
  logic [47:0]             s2_norm;

  assign s2_norm = s2_m << s2_lz;

  // stage 1 multiply, stage 2 leading zero count, stage 3 normalize
  always_ff @(posedge clk) begin
    s1_m    <= a_m * b_m;
    s1_e    <= a_e + b_e;
    s1_sign <= a_bits[31] ^ b_bits[31];
    s1_zero <= a_zero | b_zero;
    s1_inf  <= a_inf | b_inf;
    s1_nan  <= a_nan | b_nan | (a_zero & b_inf) | (a_inf & b_zero);

    s2_m    <= s1_m;
    s2_e    <= s1_e;
    s2_lz   <= lzc48(s1_m);
    s2_sign <= s1_sign;
    s2_zero <= s1_zero;
    s2_inf  <= s1_inf;
    s2_nan  <= s1_nan;

    prod.nan  <= s2_nan;
    prod.inf  <= s2_inf;
    prod.zero <= s2_zero;
    prod.sign <= s2_sign;
    if (s2_zero) begin
      prod.exp  <= ZERO_EXP;
      prod.mant <= 53'd0;
    end else begin
      prod.exp  <= s2_e + 13'sd47 - signed'({7'b0, s2_lz});
      prod.mant <= {s2_norm, 5'b0};
    end
  end

endmodule

[design/rsmm_add_unit.sv]
// pipelined binary64 adder, round to nearest even, for accumulator updates
module rsmm_add_unit
  import rsmm_pkg::*;
(
  input  logic        clk,
  input  prod_t       prod,
  input  logic [63:0] acc_bits,
  output logic [63:0] sum_bits
);

  function automatic logic [5:0] lzc57(input logic [56:0] v);
    logic [5:0] n;
    n = 6'd56;
    for (int i = 0; i < 57; i++) begin
      if (v[i]) n = 6'(56 - i);
    end
    return n;
  endfunction

  // accumulator operand unpack
  logic [10:0]             c_ex;
  logic [51:0]             c_fr;
  logic                    c_zero, c_inf, c_nan;
  logic signed [EXP_W-1:0] c_e;
  logic [52:0]             c_m;

  assign c_ex   = acc_bits[62:52];
  assign c_fr   = acc_bits[51:0];
  assign c_zero = (c_ex == 11'd0);
  assign c_inf  = (c_ex == 11'h7FF) && (c_fr == 52'd0);
  assign c_nan  = (c_ex == 11'h7FF) && (c_fr != 52'd0);
  assign c_e    = c_zero ? ZERO_EXP : signed'({2'b0, c_ex}) - F64_BIAS;
  assign c_m    = c_zero ? 53'd0 : {1'b1, c_fr};

  // operand order and special results
  logic                    p_big;
  logic signed [EXP_W-1:0] d_full;
  logic                    r_nan, r_inf, r_zero;
  logic [63:0]             r_bits;

  assign p_big  = (prod.exp > c_e) || ((prod.exp == c_e) && (prod.mant >= c_m));
  assign d_full = p_big ? (prod.exp - c_e) : (c_e - prod.exp);
  assign r_nan  = prod.nan | c_nan | (prod.inf & c_inf & (prod.sign != acc_bits[63]));
  assign r_inf  = prod.inf | c_inf;
  assign r_zero = prod.zero & c_zero;

  always_comb begin
    if (r_nan) begin
      r_bits = CANON_NAN;
    end else if (r_inf) begin
      r_bits = {(c_inf ? acc_bits[63] : prod.sign), 11'h7FF, 52'd0};
    end else begin
      r_bits = {prod.sign & acc_bits[63], 63'd0};
    end
  end

  logic                    s4_sb, s4_sub, s4_spec;
  logic signed [EXP_W-1:0] s4_eb;
  logic [52:0]             s4_mb, s4_ms;
  logic [5:0]              s4_d;
  logic [63:0]             s4_spec_bits;

  // align the smaller operand with a sticky bit
  logic [56:0] al_src, al_shr, al_mask;
  logic        al_stk;

  assign al_src  = {1'b0, s4_ms, 3'b0};
  assign al_shr  = al_src >> s4_d;
  assign al_mask = (57'd1 << s4_d) - 57'd1;
  assign al_stk  = |(al_src & al_mask);

  logic                    s5_sb, s5_sub, s5_spec;
  logic signed [EXP_W-1:0] s5_eb;
  logic [56:0]             s5_b, s5_s;
  logic [63:0]             s5_spec_bits;

  logic                    s6_sb, s6_spec;
  logic signed [EXP_W-1:0] s6_eb;
  logic [56:0]             s6_sum;
  logic [63:0]             s6_spec_bits;

  logic                    s7_sb, s7_spec, s7_zero;
  logic signed [EXP_W-1:0] s7_eb;
  logic [56:0]             s7_sum;
  logic [5:0]              s7_lz;
  logic [63:0]             s7_spec_bits;

  // normalize and pick the rounding increment
  logic [56:0] nm;
  assign nm = s7_sum << s7_lz;

  logic                    s8_sb, s8_spec, s8_zero, s8_inc;
  logic signed [EXP_W-1:0] s8_e;
  logic [52:0]             s8_m;
  logic [63:0]             s8_spec_bits;

  // round and pack
  logic [53:0]             rd_m;
  logic signed [EXP_W-1:0] rd_e, rd_biased;
  logic [51:0]             rd_frac;

  assign rd_m      = {1'b0, s8_m} + 54'(s8_inc);
  assign rd_e      = rd_m[53] ? (s8_e + 13'sd1) : s8_e;
  assign rd_frac   = rd_m[53] ? 52'd0 : rd_m[51:0];
  assign rd_biased = rd_e + F64_BIAS;

  always_ff @(posedge clk) begin
    // stage 4 swap
    s4_sb        <= p_big ? prod.sign : acc_bits[63];
    s4_sub       <= prod.sign ^ acc_bits[63];
    s4_eb        <= p_big ? prod.exp : c_e;
    s4_mb        <= p_big ? prod.mant : c_m;
    s4_ms        <= p_big ? c_m : prod.mant;
    s4_d         <= (d_full > 13'sd63) ? 6'd63 : d_full[5:0];
    s4_spec      <= r_nan | r_inf | r_zero;
    s4_spec_bits <= r_bits;

    // stage 5 align
    s5_sb        <= s4_sb;
    s5_sub       <= s4_sub;
    s5_eb        <= s4_eb;
    s5_b         <= {1'b0, s4_mb, 3'b0};
    s5_s         <= al_shr | {56'd0, al_stk};
    s5_spec      <= s4_spec;
    s5_spec_bits <= s4_spec_bits;

    // stage 6 add or subtract magnitudes
    s6_sb        <= s5_sb;
    s6_eb        <= s5_eb;
    s6_sum       <= s5_sub ? (s5_b - s5_s) : (s5_b + s5_s);
    s6_spec      <= s5_spec;
    s6_spec_bits <= s5_spec_bits;

    // stage 7 leading zero count
    s7_sb        <= s6_sb;
    s7_eb        <= s6_eb;
    s7_sum       <= s6_sum;
    s7_lz        <= lzc57(s6_sum);
    s7_zero      <= (s6_sum == 57'd0);
    s7_spec      <= s6_spec;
    s7_spec_bits <= s6_spec_bits;

    // stage 8 normalize
    s8_sb        <= s7_sb;
    s8_e         <= s7_eb + 13'sd1 - signed'({7'b0, s7_lz});
    s8_m         <= nm[56:4];
    s8_inc       <= nm[3] & ((|nm[2:0]) | nm[4]);
    s8_zero      <= s7_zero;
    s8_spec      <= s7_spec;
    s8_spec_bits <= s7_spec_bits;

    // stage 9 round and pack
    if (s8_spec) begin
      sum_bits <= s8_spec_bits;
    end else if (s8_zero) begin
      sum_bits <= 64'd0;
    end else if (rd_biased >= F64_EXP_TOP) begin
      sum_bits <= {s8_sb, 11'h7FF, 52'd0};
    end else begin
      sum_bits <= {s8_sb, rd_biased[10:0], rd_frac};
    end
  end

endmodule

[design/row_streamed_matrix_multiply_core.sv]
// top level of the row-streamed matrix multiply core
//
// Input stream: s_axis_tuser selects the request kind. Kind load-B writes one
// binary32 element of B into the on-chip B memory. Kind row-A carries
// a[i][k]; the core then walks j = 0..N-1 through one shared multiply-add
// pipeline, reading B[k][j] and the row accumulator entry j from memory and
// writing the rounded binary64 sum back. An A request is issued one j at a
// time through the single multiply-add pipeline, fed by one read port per
// memory, and no new request is taken until the pipeline has drained. A
// request with k = N-1 then emits the N results of the row on m_axis, with
// tlast on j = N-1, and clears the accumulator.
// Requests with k at or above N are dropped; so are B writes outside MAX_N.
// cfg_valid/cfg_data write the size N; write it only while the core is idle.
// Reset clears the control state, sets N to 64 and marks every accumulator
// entry as zero at once; the B memory is not cleared, no clearing pass runs.
// A stalled receiver holds the result in the output register; the core keeps
// accepting requests until it needs that register again.
module row_streamed_matrix_multiply_core
  import rsmm_pkg::*;
#(
  parameter int MAX_N = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write: size in use
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [SIZE_W-1:0]     cfg_data,
  // request stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // elem_row, elem_col, elem_value
  input  logic                  s_axis_tuser,  // kind
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // out_row, out_col, out_value
  output logic                  m_axis_tlast   // last_of_row
);

  localparam int IW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int BD = MAX_N * MAX_N;
  localparam int AW = (BD > 1) ? $clog2(BD) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_DRAIN,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  state_t state;

  // request fields
  logic [5:0]  in_row, in_col;
  logic [31:0] in_val;
  logic        in_acc;

  assign in_row = s_axis_tdata[5:0];
  assign in_col = s_axis_tdata[11:6];
  assign in_val = s_axis_tdata[43:12];
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // size register and active size
  logic [SIZE_W-1:0] size_in_use, n_act;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (size_in_use == '0) begin
      n_act = SIZE_W'(1);
    end else if (size_in_use > SIZE_W'(MAX_N)) begin
      n_act = SIZE_W'(MAX_N);
    end else begin
      n_act = size_in_use;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= SIZE_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      size_in_use <= cfg_data;
    end
  end

  // held request
  logic [5:0]        it_row;
  logic [IW-1:0]     it_col;
  logic [31:0]       it_a;
  logic              it_close;
  logic [SIZE_W-1:0] it_n;
  logic [IW-1:0]     j;
  logic              j_last;

  assign j_last = (SIZE_W'(j) == (it_n - SIZE_W'(1)));

  // B memory
  logic [31:0] b_mem [BD];
  logic [31:0] b_q;
  logic        b_wr;
  logic [AW-1:0] b_wr_addr, b_rd_addr;

  assign b_wr = (state == ST_IDLE) && in_acc && (s_axis_tuser == KIND_LOAD_B) &&
                ({1'b0, in_row} < SIZE_W'(MAX_N)) && ({1'b0, in_col} < SIZE_W'(MAX_N));
  assign b_wr_addr = AW'(in_row[IW-1:0]) * AW'(MAX_N) + AW'(in_col[IW-1:0]);
  assign b_rd_addr = AW'(it_col) * AW'(MAX_N) + AW'(j);

  always_ff @(posedge clk) begin
    if (b_wr) begin
      b_mem[b_wr_addr] <= in_val;
    end
    b_q <= b_mem[b_rd_addr];
  end

  // accumulator memory with per-entry valid bits
  logic [63:0]      acc_mem [MAX_N];
  logic [63:0]      acc_q;
  logic             accv_q;
  logic [MAX_N-1:0] acc_vld;
  logic [63:0]      acc_rd;
  logic [63:0]      sum_bits;

  logic             tag_vld [PIPE_DEPTH];
  logic [IW-1:0]    tag_idx [PIPE_DEPTH];
  logic             tags_busy;
  logic             acc_clear;

  assign acc_rd = accv_q ? acc_q : 64'd0;

  always_ff @(posedge clk) begin
    if (tag_vld[PIPE_DEPTH-1]) begin
      acc_mem[tag_idx[PIPE_DEPTH-1]] <= sum_bits;
    end
    acc_q  <= acc_mem[j];
    accv_q <= acc_vld[j];
  end

  always_ff @(posedge clk) begin
    if (rst || acc_clear) begin
      acc_vld <= '0;
    end else if (tag_vld[PIPE_DEPTH-1]) begin
      acc_vld[tag_idx[PIPE_DEPTH-1]] <= 1'b1;
    end
  end

  // issue tags follow each j through the arithmetic pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < PIPE_DEPTH; k++) tag_vld[k] <= 1'b0;
    end else begin
      tag_vld[0] <= (state == ST_UPD);
      for (int k = 1; k < PIPE_DEPTH; k++) tag_vld[k] <= tag_vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    tag_idx[0] <= j;
    for (int k = 1; k < PIPE_DEPTH; k++) tag_idx[k] <= tag_idx[k-1];
  end

  always_comb begin
    tags_busy = 1'b0;
    for (int k = 0; k < PIPE_DEPTH; k++) tags_busy = tags_busy | tag_vld[k];
  end

  // accumulator operand delayed to meet the product
  logic [63:0] acc_dly [MUL_LAT];

  always_ff @(posedge clk) begin
    acc_dly[0] <= acc_rd;
    for (int k = 1; k < MUL_LAT; k++) acc_dly[k] <= acc_dly[k-1];
  end

  // multiply-add pipeline
  prod_t prod;

  rsmm_mul_unit u_mul (
    .clk    (clk),
    .a_bits (it_a),
    .b_bits (b_q),
    .prod   (prod)
  );

  rsmm_add_unit u_add (
    .clk      (clk),
    .prod     (prod),
    .acc_bits (acc_dly[MUL_LAT-1]),
    .sum_bits (sum_bits)
  );

  // result value with NaN made canonical
  logic [63:0] out_val;
  assign out_val = ((acc_rd[62:52] == 11'h7FF) && (acc_rd[51:0] != 52'd0)) ? CANON_NAN : acc_rd;

  assign s_axis_tready = (state == ST_IDLE);
  assign acc_clear     = (state == ST_EMIT_LD) && j_last;

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      j             <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          j <= '0;
          if (in_acc && (s_axis_tuser == KIND_ROW_A) && ({1'b0, in_col} < n_act)) begin
            it_row   <= in_row;
            it_col   <= in_col[IW-1:0];
            it_a     <= in_val;
            it_n     <= n_act;
            it_close <= ({1'b0, in_col} == (n_act - SIZE_W'(1)));
            state    <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (j_last) begin
            j     <= '0;
            state <= ST_DRAIN;
          end else begin
            j <= j + IW'(1);
          end
        end
        ST_DRAIN: begin
          if (!tags_busy) begin
            state <= it_close ? ST_EMIT_RD : ST_IDLE;
          end
        end
        ST_EMIT_RD: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            state <= ST_EMIT_LD;
          end
        end
        ST_EMIT_LD: begin
          m_axis_tvalid <= 1'b1;
          m_axis_tdata  <= {4'b0, out_val, 6'(j), it_row};
          m_axis_tlast  <= j_last;
          if (j_last) begin
            j     <= '0;
            state <= ST_IDLE;
          end else begin
            j     <= j + IW'(1);
            state <= ST_EMIT_RD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[design/rsmm_checker.sv]
// port-level checks of the result stream, bound to the core
module rsmm_checker
  import rsmm_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tlast
);

  logic       out_acc;
  logic [5:0] exp_col, run_row;
  logic       in_run;

  assign out_acc = m_axis_tvalid && m_axis_tready;

  // track position within the current row
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_col <= '0;
      in_run  <= 1'b0;
    end else if (out_acc) begin
      exp_col <= m_axis_tlast ? 6'd0 : (m_axis_tdata[11:6] + 6'd1);
      in_run  <= !m_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc) run_row <= m_axis_tdata[5:0];
  end

  // columns of a row come out in rising order from zero
  a_col_order: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> (m_axis_tdata[11:6] == exp_col))
    else $error("result column out of order");

  // all results of one row carry the same row index
  a_row_same: assert property (@(posedge clk) disable iff (rst)
    out_acc && in_run |-> (m_axis_tdata[5:0] == run_row))
    else $error("row index changed within a row");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind row_streamed_matrix_multiply_core rsmm_checker u_rsmm_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

[verif/tb.sv]
// testbench for the row-streamed matrix multiply core
`timescale 1ns / 1ps

module tb;
  import rsmm_pkg::*;

  localparam int MAXN       = 64;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_WAIT = 120;
  localparam int LONG_HOLD  = 500;

  typedef struct {
    logic [5:0]  row;
    logic [5:0]  col;
    logic [63:0] value;
    logic        last;
  } product_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [SIZE_W-1:0]     cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;  // elem_row, elem_col, elem_value
  logic                  s_axis_tuser = 1'b0;  // kind
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;  // out_row, out_col, out_value
  logic                  m_axis_tlast;  // last_of_row

  // predictor state
  logic [31:0]   b_copy [MAXN*MAXN];
  bit            b_written [MAXN*MAXN];
  real           row_sum [MAXN];
  logic [6:0]    size_reg = 7'd64;
  product_t      pending_products [$];

  int errors = 0;
  int requests_sent = 0;
  int products_seen = 0;
  int rows_closed = 0;
  int burst_left = 0;
  int hold_pending = 0;
  int idle_cycles = 0;

  row_streamed_matrix_multiply_core #(.MAX_N(MAXN)) DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int active_size();
    if (size_reg == 0) return 1;
    if (size_reg > MAXN) return MAXN;
    return size_reg;
  endfunction

  // exact widening of a binary32 pattern to a binary64 value
  function automatic real widen_f32(input logic [31:0] f);
    logic [7:0]  e;
    logic [22:0] m;
    logic [10:0] e64;
    int          sh;
    e = f[30:23];
    m = f[22:0];
    sh = 0;
    if (e == 8'hFF) begin
      e64 = 11'h7FF;
    end else if (e == 0 && m == 0) begin
      e64 = 0;
    end else if (e == 0) begin
      while (!m[22]) begin
        m = m << 1;
        sh++;
      end
      m = m << 1;
      e64 = 11'(896 - sh);
    end else begin
      e64 = 11'(e + 896);
    end
    return $bitstoreal({f[31], e64, m, 29'b0});
  endfunction

  // record a B write, or accumulate one accepted A request and queue the row it closes
  task automatic predict_request(input logic kind, input logic [5:0] row,
                                 input logic [5:0] col, input logic [31:0] val);
    int          n;
    real         a;
    logic [63:0] bits;
    product_t    p;
    n = active_size();
    if (kind == KIND_LOAD_B) begin
      b_copy[row*MAXN+col] = val;
      b_written[row*MAXN+col] = 1'b1;
      return;
    end
    if (col >= n) return;
    a = widen_f32(val);
    for (int j = 0; j < n; j++)
      row_sum[j] = row_sum[j] + a * widen_f32(b_copy[col*MAXN+j]);
    if (col != n - 1) return;
    for (int j = 0; j < n; j++) begin
      bits = $realtobits(row_sum[j]);
      if (bits[62:52] == 11'h7FF && bits[51:0] != 0) bits = CANON_NAN;
      p.row = row;
      p.col = 6'(j);
      p.value = bits;
      p.last = (j == n - 1);
      pending_products.push_back(p);
    end
    for (int j = 0; j < MAXN; j++) row_sum[j] = 0.0;
    rows_closed++;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    errors++;
    $display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
  endtask

  // send one request, with bursts and random gaps
  task automatic send_request(input logic kind, input logic [5:0] row,
                              input logic [5:0] col, input logic [31:0] val);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {4'b0, val, col, row};
    do @(posedge clk); while (!s_axis_tready);
    requests_sent++;
    predict_request(kind, row, col, val);
  endtask

  // drop valid and wait until every product has come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    wait (pending_products.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_size(input logic [6:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    size_reg = v;
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] specials [8] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000,
                                  32'hFF80_0000, 32'h7FC0_0000, 32'h7F7F_FFFF,
                                  32'h0000_0001, 32'h3F80_0000};
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return specials[$urandom_range(0, 7)];
    if (pick < 4) return $urandom();
    return {1'($urandom()), 8'($urandom_range(110, 144)), 23'($urandom())};
  endfunction

  // make sure the B row read by an A request holds written entries
  task automatic load_b_row(input int k);
    int n;
    n = active_size();
    for (int j = 0; j < n; j++)
      if (!b_written[k*MAXN+j]) send_request(KIND_LOAD_B, 6'(k), 6'(j), pick_value());
  endtask

  task automatic send_row(input logic [5:0] i, input int first_k);
    int n;
    n = active_size();
    for (int k = first_k; k < n; k++) begin
      load_b_row(k);
      send_request(KIND_ROW_A, i, 6'(k), pick_value());
    end
  endtask

  // check each product against the oldest expectation
  always @(posedge clk) begin
    product_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      products_seen++;
      if (pending_products.size() == 0) begin
        report_mismatch("unexpected product", 64'd0, m_axis_tdata[75:12]);
      end else begin
        want = pending_products.pop_front();
        if (m_axis_tdata[5:0] != want.row)
          report_mismatch("out_row", 64'(want.row), 64'(m_axis_tdata[5:0]));
        if (m_axis_tdata[11:6] != want.col)
          report_mismatch("out_col", 64'(want.col), 64'(m_axis_tdata[11:6]));
        if (m_axis_tdata[75:12] !== want.value)
          report_mismatch("out_value", want.value, m_axis_tdata[75:12]);
        if (m_axis_tlast !== want.last)
          report_mismatch("last_of_row", 64'(want.last), 64'(m_axis_tlast));
      end
    end
  end

  // receiver stall pattern, with an occasional long hold
  always @(posedge clk) begin
    int cyc;
    int hold_left;
    cyc++;
    if (hold_pending != 0) begin
      hold_pending = 0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case ((cyc / 300) % 4)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= (cyc % 4 == 0);
        default: m_axis_tready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("timeout waiting for a handshake at %0t", $realtime);
      $display("row_streamed_matrix_multiply_core regression: fail");
      $finish;
    end
  end

  // extremes, specials, ignored and mixed rows at a small size
  task automatic test_directed();
    logic [31:0] picks [4] = '{32'h7F7F_FFFF, 32'h0000_0001, 32'h8000_0000, 32'hFFFF_FFFF};
    write_size(7'd4);
    for (int k = 0; k < 4; k++)
      for (int j = 0; j < 4; j++)
        send_request(KIND_LOAD_B, 6'(k), 6'(j), (k == j) ? 32'h3F80_0000 : picks[(k+j)%4]);
    send_request(KIND_LOAD_B, 6'd63, 6'd63, 32'h4000_0000);
    send_row(6'd63, 0);
    // request with k beyond the size is dropped
    send_request(KIND_ROW_A, 6'd1, 6'd63, 32'h3F80_0000);
    // mixed rows share the accumulator; inf and nan sources
    send_request(KIND_ROW_A, 6'd2, 6'd0, 32'h7F80_0000);
    send_request(KIND_ROW_A, 6'd5, 6'd1, 32'h0000_0000);
    send_request(KIND_ROW_A, 6'd0, 6'd2, 32'h7FC0_0001);
    send_request(KIND_ROW_A, 6'd0, 6'd3, 32'h8000_0001);
  endtask

  // size register extremes, out-of-range values and a change mid-row
  task automatic test_sizes();
    logic [6:0] sizes [5] = '{7'd0, 7'd1, 7'd127, 7'd64, 7'd8};
    foreach (sizes[s]) begin
      write_size(sizes[s]);
      send_row(6'($urandom_range(0, 63)), active_size() > 4 ? active_size() - 3 : 0);
    end
    send_row(6'd7, 4);
    for (int k = 0; k < 6; k++) send_request(KIND_ROW_A, 6'd9, 6'(k), pick_value());
    write_size(7'd4);
    send_row(6'd9, 3);
  endtask

  // random rows with noise, mostly small sizes, up to the overall request count
  task automatic test_random();
    int target;
    int n;
    target = 350;
    while (requests_sent < target) begin
      write_size(($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                             : 7'($urandom_range(1, 8)));
      n = active_size();
      repeat ($urandom_range(2, 6)) begin
        if ($urandom_range(0, 9) < 7) begin
          send_row(6'($urandom()), n > 8 ? n - $urandom_range(1, 4) : 0);
        end else if ($urandom_range(0, 1) == 0) begin
          send_request(KIND_LOAD_B, 6'($urandom()), 6'($urandom()), pick_value());
        end else begin
          int k = $urandom_range(0, 63);
          if (k < n) load_b_row(k);
          send_request(KIND_ROW_A, 6'($urandom()), 6'(k), pick_value());
        end
      end
    end
  endtask

  // long receiver hold while requests keep coming
  task automatic test_backpressure();
    write_size(7'd4);
    hold_pending = 1;
    burst_left = 200;
    repeat (10) send_row(6'($urandom()), 0);
    drain();
  endtask

  initial begin
    for (int j = 0; j < MAXN; j++) row_sum[j] = 0.0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_sizes();
    test_backpressure();
    test_random();
    drain();
    $display("covered %0d requests, %0d rows closed, %0d products checked",
             requests_sent, rows_closed, products_seen);
    $display("sizes 0 to 127, special operands, dropped and mixed rows, long stalls");
    if (errors == 0)
      $display("row_streamed_matrix_multiply_core regression: pass");
    else
      $display("row_streamed_matrix_multiply_core regression: fail");
    $finish;
  end

endmodule
